FILE: hw/rtl/sffp_pkg.sv
// ----------------------------------------------------------------------------
// Servo frame packer package
// Shared widths, register indexes, sync bytes and the frame segment record
// that travels from the framer to the byte serializer.
// ----------------------------------------------------------------------------
package sffp_pkg;

  // Default frame sizes
  localparam int unsigned MAX_SERVOS_DEF  = 16;
  localparam int unsigned FIXED_SLOTS_DEF = 8;

  // Field and port widths
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned OCTET_W    = 8;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // One input item yields at most seven bytes
  localparam int unsigned SEG_DEPTH = 7;
  localparam int unsigned SEG_CNT_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_VARIABLE_FORMAT = 1'b0,
    CFG_SERVO_COUNT     = 1'b1
  } cfg_reg_t;

  typedef logic [OCTET_W-1:0] octet_t;

  // Sync bytes of both frame formats
  localparam octet_t SYNC_FIXED_0 = 8'hFF;
  localparam octet_t SYNC_FIXED_1 = 8'hEE;
  localparam octet_t SYNC_VAR_0   = 8'hFE;
  localparam octet_t SYNC_VAR_1   = 8'hEF;

  // Byte counts of one segment
  localparam logic [SEG_CNT_W-1:0] SEG_BODY       = 3'd2;
  localparam logic [SEG_CNT_W-1:0] SEG_BODY_CK    = 3'd4;
  localparam logic [SEG_CNT_W-1:0] SEG_FIXED      = 3'd4;
  localparam logic [SEG_CNT_W-1:0] SEG_FIXED_CK   = 3'd6;
  localparam logic [SEG_CNT_W-1:0] SEG_VAR        = 3'd5;
  localparam logic [SEG_CNT_W-1:0] SEG_VAR_CK     = 3'd7;

  // Configuration as seen by the framer
  typedef struct packed {
    logic               variable_format;
    logic [COUNT_W-1:0] servo_count;
  } cfg_t;

  // Bytes produced by one input item, lowest entry sent first
  typedef struct packed {
    octet_t [SEG_DEPTH-1:0] bytes;
    logic [SEG_CNT_W-1:0]   count;
    logic                   closes;
  } seg_t;

endpackage

FILE: hw/rtl/sffp_framer.sv
// ----------------------------------------------------------------------------
// Servo frame packer: framer
// Takes one pulse value per transfer, tracks slot position and Fletcher sums,
// and registers the full byte segment that the item adds to the frame.
// ----------------------------------------------------------------------------
module sffp_framer #(
  parameter int unsigned MAX_SERVOS  = sffp_pkg::MAX_SERVOS_DEF,
  parameter int unsigned FIXED_SLOTS = sffp_pkg::FIXED_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sffp_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sffp_pkg::PULSE_W-1:0]   in_pulse,
  output logic                           seg_valid,
  input  logic                           seg_ready,
  output sffp_pkg::seg_t                 seg
);
  import sffp_pkg::*;

  localparam int unsigned MAX_LEN = (MAX_SERVOS > FIXED_SLOTS) ? MAX_SERVOS : FIXED_SLOTS;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);

  logic [LEN_W-1:0] slot_index, slot_index_next;
  octet_t           sum_a, sum_a_next;
  octet_t           sum_b, sum_b_next;
  octet_t           frame_len;
  logic             frame_start;
  logic             closes;
  logic             accept;
  octet_t           pulse_hi, pulse_lo;
  octet_t           a0, b0, a1, b1, a2, b2;
  seg_t             seg_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = !seg_valid || seg_ready;
  assign pulse_hi = in_pulse[PULSE_W-1:OCTET_W];
  assign pulse_lo = in_pulse[OCTET_W-1:0];

  // Slots per frame: FIXED_SLOTS, or the servo count clamped to 1..MAX_SERVOS.
  always_comb begin
    if (!cfg.variable_format) begin
      frame_len = OCTET_W'(FIXED_SLOTS);
    end else if (cfg.servo_count == '0) begin
      frame_len = 8'd1;
    end else if (OCTET_W'(cfg.servo_count) > OCTET_W'(MAX_SERVOS)) begin
      frame_len = OCTET_W'(MAX_SERVOS);
    end else begin
      frame_len = OCTET_W'(cfg.servo_count);
    end
  end

  assign frame_start = (slot_index == '0);
  assign closes      = (OCTET_W'(slot_index) + 8'd1) >= frame_len;

  // Fletcher sums over the two pulse bytes; a new frame starts from zero.
  always_comb begin
    a0 = frame_start ? '0 : sum_a;
    b0 = frame_start ? '0 : sum_b;
    a1 = a0 + pulse_hi;
    b1 = b0 + a1;
    a2 = a1 + pulse_lo;
    b2 = b1 + a2;
  end

  // Next slot position and sums
  always_comb begin
    if (closes) begin
      slot_index_next = '0;
      sum_a_next      = '0;
      sum_b_next      = '0;
    end else begin
      slot_index_next = slot_index + 1'b1;
      sum_a_next      = a2;
      sum_b_next      = b2;
    end
  end

  // Segment of bytes for this item: optional header, pulse, optional checksum.
  always_comb begin
    seg_next        = '0;
    seg_next.closes = closes;
    if (!frame_start) begin
      seg_next.bytes[0] = pulse_hi;
      seg_next.bytes[1] = pulse_lo;
      seg_next.bytes[2] = a2;
      seg_next.bytes[3] = b2;
      seg_next.count    = closes ? SEG_BODY_CK : SEG_BODY;
    end else if (!cfg.variable_format) begin
      seg_next.bytes[0] = SYNC_FIXED_0;
      seg_next.bytes[1] = SYNC_FIXED_1;
      seg_next.bytes[2] = pulse_hi;
      seg_next.bytes[3] = pulse_lo;
      seg_next.bytes[4] = a2;
      seg_next.bytes[5] = b2;
      seg_next.count    = closes ? SEG_FIXED_CK : SEG_FIXED;
    end else begin
      seg_next.bytes[0] = SYNC_VAR_0;
      seg_next.bytes[1] = SYNC_VAR_1;
      seg_next.bytes[2] = frame_len;
      seg_next.bytes[3] = pulse_hi;
      seg_next.bytes[4] = pulse_lo;
      seg_next.bytes[5] = a2;
      seg_next.bytes[6] = b2;
      seg_next.count    = closes ? SEG_VAR_CK : SEG_VAR;
    end
  end

  // Frame state and segment valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index <= '0;
      sum_a      <= '0;
      sum_b      <= '0;
      seg_valid  <= 1'b0;
    end else begin
      if (accept) begin
        slot_index <= slot_index_next;
        sum_a      <= sum_a_next;
        sum_b      <= sum_b_next;
      end
      if (accept) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
    end
  end

  // Segment payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      seg <= seg_next;
    end
  end

  // A segment waiting on the serializer is held unchanged.
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg))
    else $error("framer segment changed while stalled");

  // The slot position never reaches the longest frame.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_index < LEN_W'(MAX_LEN))
    else $error("slot index out of range");

  // Closing a frame clears the position and both sums.
  a_close_clear: assert property (@(posedge clk) disable iff (rst)
    accept && closes |=> slot_index == '0 && sum_a == '0 && sum_b == '0)
    else $error("frame state not cleared after close");

endmodule

FILE: hw/rtl/sffp_serializer.sv
// ----------------------------------------------------------------------------
// Servo frame packer: byte serializer
// Holds one segment and sends its bytes one per transfer, loading the next
// segment in the cycle its last byte leaves.
// ----------------------------------------------------------------------------
module sffp_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seg_valid,
  output logic                          seg_ready,
  input  sffp_pkg::seg_t                seg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sffp_pkg::OCTET_W-1:0]  out_data,
  output logic                          out_last
);
  import sffp_pkg::*;

  seg_t                 held;
  logic                 active;
  logic [SEG_CNT_W-1:0] idx;
  logic                 last_byte;
  logic                 out_fire;
  logic                 load;

  assign last_byte = (idx == (held.count - 1'b1));
  assign out_fire  = out_valid && out_ready;
  assign seg_ready = !active || (out_fire && last_byte);
  assign load      = seg_valid && seg_ready;

  assign out_valid = active;
  assign out_data  = held.bytes[idx];
  assign out_last  = held.closes && last_byte;

  // Byte position and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (out_fire) begin
      if (last_byte) begin
        active <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Segment being sent
  always_ff @(posedge clk) begin
    if (load) begin
      held <= seg;
    end
  end

  // The byte position stays inside the held segment.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx < held.count)
    else $error("serializer index past segment end");

  // A stalled output keeps its byte position.
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    active && !out_ready |=> active && $stable(idx))
    else $error("serializer advanced without a transfer");

  // Every segment carries at least the two pulse bytes.
  a_seg_count: assert property (@(posedge clk) disable iff (rst)
    active |-> held.count >= SEG_BODY)
    else $error("held segment too short");

endmodule

FILE: hw/rtl/servo_frame_fletcher_packer.sv
// ----------------------------------------------------------------------------
// Servo frame packer with Fletcher checksum
// Turns a stream of 16-bit servo pulse values into a byte stream of framed
// servo outputs with sync header, optional count byte and two 8-bit checksum bytes.
//
//   Channel   Dir  Signals                          Content
//   s_axis    in   tvalid tready tdata[15:0]        [15:0] pulse_width
//   m_axis    out  tvalid tready tdata[7:0] tlast   [7:0] out_byte, tlast frame_end
//   cfg       in   cfg_we cfg_addr cfg_wdata[4:0]   0 variable_format, 1 servo_count
//
// Each pulse yields 2 to 7 output bytes, sent one per cycle on m_axis while
// m_axis_tready is high; the single-byte output port limits the pulse rate.
// The next pulse is taken while the previous segment is still being sent.
// Reset (rst, synchronous) empties both stages and starts a new frame.
// Output stalls back up through the segment register to s_axis_tready.
// ----------------------------------------------------------------------------
module servo_frame_fletcher_packer #(
  parameter int unsigned MAX_SERVOS  = sffp_pkg::MAX_SERVOS_DEF,
  parameter int unsigned FIXED_SLOTS = sffp_pkg::FIXED_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Pulse input: [15:0] pulse_width
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sffp_pkg::PULSE_W-1:0]      s_axis_tdata,
  // Byte output: [7:0] out_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sffp_pkg::OCTET_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,
  // Register writes
  input  logic                              cfg_we,
  input  logic [sffp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sffp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sffp_pkg::*;

  cfg_t cfg;
  logic seg_valid;
  logic seg_ready;
  seg_t seg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.variable_format <= 1'b0;
      cfg.servo_count     <= COUNT_W'(FIXED_SLOTS_DEF);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_VARIABLE_FORMAT: cfg.variable_format <= cfg_wdata[0];
        CFG_SERVO_COUNT:     cfg.servo_count     <= cfg_wdata[COUNT_W-1:0];
        default:             ;
      endcase
    end
  end

  // Slot tracking, checksum and segment build
  sffp_framer #(
    .MAX_SERVOS  (MAX_SERVOS),
    .FIXED_SLOTS (FIXED_SLOTS)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pulse  (s_axis_tdata),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  // Byte-wide output
  sffp_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: dv/servo_frame_fletcher_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo frame packer testbench
// Streams pulse values into the packer and checks every output byte and its
// frame-end flag against a frame builder kept in step with the register
// settings. Covers both frame formats, count clamping, frame length and
// format changes in the middle of a frame, a long output stall, and random
// frames with random idling on both streams.
// ----------------------------------------------------------------------------
module servo_frame_fletcher_packer_tb;
  import sffp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 140;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One expected byte of the frame stream
  typedef struct packed {
    octet_t data;
    logic   last;
  } frame_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PULSE_W-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OCTET_W-1:0]    m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Frame builder state, mirrors the packer
  logic               fmt_var = 1'b0;
  logic [COUNT_W-1:0] servo_cnt = 5'd8;
  int unsigned        slot_pos = 0;
  octet_t             fl_a = '0;
  octet_t             fl_b = '0;
  frame_byte_t        frame_q[$];

  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_gap = 0;

  servo_frame_fletcher_packer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [15:0] pulse_width
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [PULSE_W-1:0] pick_pulse();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PULSE_W'($urandom);
    endcase
  endfunction

  // Pulse byte: goes out and feeds the Fletcher sums
  function automatic void push_pulse_byte(octet_t b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
    frame_q.push_back('{data: b, last: 1'b0});
  endfunction

  // Expected bytes for one accepted pulse
  function automatic void pack_pulse(logic [PULSE_W-1:0] pw);
    int unsigned n;
    if (!fmt_var) begin
      n = FIXED_SLOTS_DEF;
    end else if (servo_cnt == 0) begin
      n = 1;
    end else if (servo_cnt > MAX_SERVOS_DEF) begin
      n = MAX_SERVOS_DEF;
    end else begin
      n = servo_cnt;
    end
    // The header goes out ahead of the first slot only
    if (slot_pos == 0) begin
      fl_a = '0;
      fl_b = '0;
      if (!fmt_var) begin
        frame_q.push_back('{data: SYNC_FIXED_0, last: 1'b0});
        frame_q.push_back('{data: SYNC_FIXED_1, last: 1'b0});
      end else begin
        frame_q.push_back('{data: SYNC_VAR_0, last: 1'b0});
        frame_q.push_back('{data: SYNC_VAR_1, last: 1'b0});
        frame_q.push_back('{data: octet_t'(n), last: 1'b0});
      end
    end
    push_pulse_byte(pw[15:8]);
    push_pulse_byte(pw[7:0]);
    // The frame length is taken fresh on every slot
    if (slot_pos + 1 >= n) begin
      frame_q.push_back('{data: fl_a, last: 1'b0});
      frame_q.push_back('{data: fl_b, last: 1'b1});
      slot_pos = 0;
      fl_a = '0;
      fl_b = '0;
    end else begin
      slot_pos = slot_pos + 1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Input transfers update the frame builder; output transfers are checked
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pack_pulse(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing pending", m_axis_tdata));
        end else begin
          want = frame_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.data));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("frame_end %0b, want %0b on byte %02h",
                                      m_axis_tlast, want.last, want.data));
          end
        end
      end
    end
  end

  // Byte sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap        <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      rx_gap        <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one pulse and returns just after the edge that takes it
  task automatic send_pulse(input logic [PULSE_W-1:0] pw);
    int unsigned gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 1) == 0) begin
      gap = pick_gap();
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pw;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops input and waits until every expected byte has come out
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write once the packer is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_VARIABLE_FORMAT: fmt_var   = val[0];
      CFG_SERVO_COUNT:     servo_cnt = val[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One full frame in the reset format, with extreme pulse values
  task automatic test_fixed_frame();
    send_pulse(16'h0000);
    send_pulse(16'hFFFF);
    send_pulse(16'h8000);
    send_pulse(16'h0001);
    send_pulse(16'h00FF);
    send_pulse(16'hFF00);
    send_pulse(16'h5AA5);
    send_pulse(16'hA55A);
  endtask

  // Counted format with a count of zero, then a count above the maximum
  task automatic test_count_limits();
    write_reg(CFG_VARIABLE_FORMAT, 5'b11111);
    write_reg(CFG_SERVO_COUNT, 5'd0);
    send_pulse(16'h1234);
    write_reg(CFG_SERVO_COUNT, 5'd31);
    send_pulse(16'hFFFF);
    send_pulse(16'h0000);
  endtask

  // Shortening the frame past the current slot closes it on the next pulse
  task automatic test_length_change();
    write_reg(CFG_SERVO_COUNT, 5'd2);
    send_pulse(16'hC3C3);
    send_pulse(16'h7FFF);
    send_pulse(16'h8001);
  endtask

  // Format switch mid-frame: no new header, length follows the new format
  task automatic test_format_change();
    write_reg(CFG_VARIABLE_FORMAT, 5'b11110);
    send_pulse(16'h0102);
    send_pulse(16'hFEDC);
    write_reg(CFG_SERVO_COUNT, 5'd3);
    write_reg(CFG_VARIABLE_FORMAT, 5'd1);
    send_pulse(16'hABCD);
    send_pulse(16'h4321);
  endtask

  // Long sink hold-off while pulses keep coming back to back
  task automatic test_backpressure();
    write_reg(CFG_SERVO_COUNT, 5'd16);
    tx_idle_en = 1'b0;
    hold_seq <= hold_seq + 1;
    repeat (20) send_pulse(pick_pulse());
    tx_idle_en = 1'b1;
  endtask

  // Random settings, each followed by a run of random pulses
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned run_len;
    logic [CFG_DATA_W-1:0] cnt_val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_VARIABLE_FORMAT, CFG_DATA_W'($urandom_range(0, 31)));
      end
      case ($urandom_range(0, 5))
        0: cnt_val = 5'd0;
        1: cnt_val = 5'd1;
        2: cnt_val = 5'd16;
        3: cnt_val = 5'd31;
        default: cnt_val = CFG_DATA_W'($urandom_range(2, 20));
      endcase
      write_reg(CFG_SERVO_COUNT, cnt_val);
      // Some runs go without any idling on either stream
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en <= tx_idle_en;
      run_len = $urandom_range(5, 30);
      repeat (run_len) send_pulse(pick_pulse());
      sent += run_len;
    end
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fixed_frame();
    test_count_limits();
    test_length_change();
    test_format_change();
    test_backpressure();
    test_random_frames();
    drain_pipeline();
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sffp_pkg.sv
hw/rtl/sffp_framer.sv
hw/rtl/sffp_serializer.sv
hw/rtl/servo_frame_fletcher_packer.sv
dv/servo_frame_fletcher_packer_tb.sv
